// File: src/pps_pkg.sv
// shared types and constants for the polyline perpendicular simplifier
package pps_pkg;

  localparam int THR_W = 32;
  localparam logic [THR_W-1:0] THR_RESET = 32'd4;

  // control sequencer, one-hot
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DIFF   = 9'b000000010,
    ST_SQR    = 9'b000000100,
    ST_LEN    = 9'b000001000,
    ST_RMUL   = 9'b000010000,
    ST_RSUM   = 9'b000100000,
    ST_SCAN   = 9'b001000000,
    ST_DECIDE = 9'b010000000,
    ST_PUT    = 9'b100000000
  } state_t;

endpackage

// File: src/pps_cell.sv
// one window cell: holds a stored vertex and a scan copy that shifts toward cell zero
module pps_cell import pps_pkg::*; #(
  parameter int PW = 32
) (
  input  logic          clk,
  input  logic          push,
  input  logic          load,
  input  logic          shift,
  input  logic [PW-1:0] win_in,
  input  logic [PW-1:0] scn_in,
  output logic [PW-1:0] win_out,
  output logic [PW-1:0] scn_out
);

  logic [PW-1:0] win_r;
  logic [PW-1:0] scn_r;

  // window entry takes its newer neighbor on a push
  always_ff @(posedge clk) begin
    if (push) begin
      win_r <= win_in;
    end
  end

  // scan copy loads from the window, then moves one cell per issued test
  always_ff @(posedge clk) begin
    if (load) begin
      scn_r <= win_r;
    end else if (shift) begin
      scn_r <= scn_in;
    end
  end

  assign win_out = win_r;
  assign scn_out = scn_r;

endmodule

// File: src/pps_dist.sv
// pipelined distance test: cross squared against threshold times length squared
module pps_dist import pps_pkg::*; #(
  parameter int CB = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              i_valid,
  input  logic [CB-1:0]     i_x,
  input  logic [CB-1:0]     i_y,
  input  logic [CB-1:0]     ax,
  input  logic [CB-1:0]     ay,
  input  logic signed [CB:0] dx,
  input  logic signed [CB:0] dy,
  input  logic [2*CB+33:0]  rhs,
  output logic              o_hit,
  output logic              busy
);

  localparam int DW   = CB + 1;
  localparam int MW   = 2 * DW;
  localparam int AW   = 2 * CB + 2;
  localparam int H    = CB + 1;
  localparam int SW   = 4 * CB + 4;
  localparam int RW   = 2 * CB + 34;
  localparam int CMPW = (SW > RW) ? SW : RW;

  logic [4:0] v_r;
  logic signed [DW-1:0] rx_r, ry_r;
  logic signed [MW-1:0] m1_r, m2_r;
  logic [AW-1:0] ac_r;
  logic [2*H-1:0] hh_r, hl_r, ll_r;
  logic hit_r;

  logic signed [MW:0] c_w;
  logic [SW-1:0] c2_w;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], i_valid};
    end
  end

  // offsets from the anchor
  always_ff @(posedge clk) begin
    rx_r <= $signed({i_x[CB-1], i_x}) - $signed({ax[CB-1], ax});
    ry_r <= $signed({i_y[CB-1], i_y}) - $signed({ay[CB-1], ay});
  end

  // cross product terms
  always_ff @(posedge clk) begin
    m1_r <= MW'(dy * rx_r);
    m2_r <= MW'(dx * ry_r);
  end

  // magnitude of the cross product
  assign c_w = $signed({m1_r[MW-1], m1_r}) - $signed({m2_r[MW-1], m2_r});
  always_ff @(posedge clk) begin
    ac_r <= c_w[MW] ? AW'(-c_w) : AW'(c_w);
  end

  // square of the magnitude as three partial products
  always_ff @(posedge clk) begin
    hh_r <= ac_r[AW-1:H] * ac_r[AW-1:H];
    hl_r <= ac_r[AW-1:H] * ac_r[H-1:0];
    ll_r <= ac_r[H-1:0] * ac_r[H-1:0];
  end

  // sum and compare
  assign c2_w = (SW'(hh_r) << (2 * H)) + (SW'(hl_r) << (H + 1)) + SW'(ll_r);
  always_ff @(posedge clk) begin
    hit_r <= CMPW'(c2_w) > CMPW'(rhs);
  end

  assign o_hit = v_r[4] & hit_r;
  assign busy  = |v_r;

endmodule

// File: src/polyline_perpendicular_simplifier.sv
// top level of the streaming closed-polygon perpendicular-distance simplifier
//
//  channel | ports                              | handshake
//  --------+------------------------------------+-----------------
//  in      | in_px in_py in_closing             | in_valid/in_ready
//  out     | out_qx out_qy out_is_last out_forced | out_valid/out_ready
//  cfg     | cfg_data (threshold_sq)            | cfg_we
//
// a first or closing vertex goes from idle through put into the output register once the slot is free.
// a middle vertex goes through five setup states, one test
// issued per stored vertex through the five-stage distance pipeline, then a decide.
// one request is worked at a time; the output register holds a waiting result
// and a new request is taken while it waits, stalling only to emit the next one.
// synchronous active-low reset clears control state; the window needs no clearing.
module polyline_perpendicular_simplifier import pps_pkg::*; #(
  parameter int WINDOW     = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_px,
  input  logic [COORD_BITS-1:0] in_py,
  input  logic                  in_closing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_qx,
  output logic [COORD_BITS-1:0] out_qy,
  output logic                  out_is_last,
  output logic                  out_forced,
  input  logic                  cfg_we,
  input  logic [THR_W-1:0]      cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int PW   = 2 * CB;
  localparam int H    = CB + 1;
  localparam int LW   = 2 * CB + 2;
  localparam int RW   = LW + THR_W;
  localparam int CNTW = $clog2(WINDOW + 1);

  state_t state_r, state_nxt;
  logic [THR_W-1:0] thr_r;
  logic [PW-1:0] anchor_r, first_r, p_r;
  logic started_r;
  logic [CNTW-1:0] cnt_r, iss_r;
  logic signed [CB:0] dx_r, dy_r;
  logic [2*H-1:0] sq1_r, sq2_r;
  logic [LW-1:0] l2_r;
  logic [H+THR_W-1:0] rlo_r, rhi_r;
  logic [RW-1:0] rhs_r;
  logic hit_r;
  logic [PW-1:0] res_pt_r;
  logic res_last_r, res_forced_r;
  logic out_valid_r;
  logic [PW-1:0] out_pt_r;
  logic out_last_r, out_forced_r;

  logic [PW-1:0] win_w [WINDOW];
  logic [PW-1:0] scn_w [WINDOW];
  logic push, load, issue, d_hit, d_busy, accept, slot_free;

  assign accept    = in_valid & in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign push      = (state_r == ST_DECIDE);
  assign load      = (state_r == ST_RSUM);
  assign issue     = (state_r == ST_SCAN) && (iss_r < cnt_r);

  // window cell chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [PW-1:0] wi, si;
    if (i == 0) begin : g_head
      assign wi = p_r;
    end else begin : g_body
      assign wi = win_w[i-1];
    end
    if (i == WINDOW - 1) begin : g_tail
      assign si = '0;
    end else begin : g_mid
      assign si = scn_w[i+1];
    end
    pps_cell #(.PW(PW)) u_cell (
      .clk(clk), .push(push), .load(load), .shift(issue),
      .win_in(wi), .scn_in(si), .win_out(win_w[i]), .scn_out(scn_w[i])
    );
  end

  // shared distance test
  pps_dist #(.CB(CB)) u_dist (
    .clk(clk), .rst_n(rst_n), .i_valid(issue),
    .i_x(scn_w[0][PW-1:CB]), .i_y(scn_w[0][CB-1:0]),
    .ax(anchor_r[PW-1:CB]), .ay(anchor_r[CB-1:0]),
    .dx(dx_r), .dy(dy_r), .rhs(rhs_r),
    .o_hit(d_hit), .busy(d_busy)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (started_r || !in_closing)) begin
          state_nxt = (in_closing || !started_r) ? ST_PUT : ST_DIFF;
        end
      end
      ST_DIFF:   state_nxt = ST_SQR;
      ST_SQR:    state_nxt = ST_LEN;
      ST_LEN:    state_nxt = ST_RMUL;
      ST_RMUL:   state_nxt = ST_RSUM;
      ST_RSUM:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!issue && !d_busy) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = (hit_r || cnt_r >= CNTW'(WINDOW)) ? ST_PUT : ST_IDLE;
      end
      ST_PUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      thr_r     <= THR_RESET;
      anchor_r  <= '0;
      first_r   <= '0;
      started_r <= 1'b0;
      cnt_r     <= '0;
      iss_r     <= '0;
      hit_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      priority if (accept && in_closing) begin
        if (started_r) begin
          started_r <= 1'b0;
          cnt_r     <= '0;
        end
      end else if (accept && !started_r) begin
        anchor_r  <= {in_px, in_py};
        first_r   <= {in_px, in_py};
        cnt_r     <= '0;
        started_r <= 1'b1;
      end else if (state_r == ST_RSUM) begin
        iss_r <= '0;
        hit_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (issue) begin
          iss_r <= iss_r + 1'b1;
        end
        if (d_hit) begin
          hit_r <= 1'b1;
        end
      end else if (state_r == ST_DECIDE) begin
        if (hit_r || cnt_r >= CNTW'(WINDOW)) begin
          anchor_r <= win_w[0];
          cnt_r    <= CNTW'(1);
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        // setup, put and idle without a request keep their values
      end
    end
  end

  // vertex latch and line setup
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= {in_px, in_py};
    end
    dx_r  <= $signed({p_r[PW-1], p_r[PW-1:CB]}) - $signed({anchor_r[PW-1], anchor_r[PW-1:CB]});
    dy_r  <= $signed({p_r[CB-1], p_r[CB-1:0]}) - $signed({anchor_r[CB-1], anchor_r[CB-1:0]});
    sq1_r <= (2*H)'(dx_r * dx_r);
    sq2_r <= (2*H)'(dy_r * dy_r);
    l2_r  <= LW'(sq1_r) + LW'(sq2_r);
    rlo_r <= l2_r[H-1:0] * thr_r;
    rhi_r <= l2_r[LW-1:H] * thr_r;
    rhs_r <= (RW'(rhi_r) << H) + RW'(rlo_r);
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      res_pt_r     <= in_closing ? first_r : {in_px, in_py};
      res_last_r   <= in_closing;
      res_forced_r <= 1'b0;
    end else if (state_r == ST_DECIDE) begin
      res_pt_r     <= win_w[0];
      res_last_r   <= 1'b0;
      res_forced_r <= !hit_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_PUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PUT && slot_free) begin
      out_pt_r     <= res_pt_r;
      out_last_r   <= res_last_r;
      out_forced_r <= res_forced_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_qx      = out_pt_r[PW-1:CB];
  assign out_qy      = out_pt_r[CB-1:0];
  assign out_is_last = out_last_r;
  assign out_forced  = out_forced_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(WINDOW)) else $error("window count above depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> cnt_r == '0) else $error("window holds points with no polygon open");

  a_pipe_scan: assert property (@(posedge clk) disable iff (!rst_n)
    d_busy |-> state_r == ST_SCAN) else $error("distance pipeline active outside scan");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> iss_r <= cnt_r) else $error("more tests issued than stored points");

endmodule
